[rtl/slfr_pkg.sv]
// Shared constants and types for the sync/length/XOR frame receiver.
package slfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    localparam int FLEN_W = 7;
    // Wide enough for a length byte plus the frame overhead.
    localparam int TGT_W  = BYTE_W + 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hCD;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hDC;

    localparam int FRAME_OVERHEAD = 6;
    localparam int LENGTH_INDEX   = 4;
    localparam int FIRST_PAYLOAD  = 2;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_REARM = 1'b1;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

endpackage

[rtl/slfr_front.sv]
// Front end: tracks sync, length and checksum, writes the frame store, posts readout commands.
module slfr_front #(
    parameter int BUFFER_DEPTH = slfr_pkg::BUFFER_DEPTH_DEF,
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1),
    localparam int ADDR_W = $clog2(BUFFER_DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic                      kind,
    input  logic [slfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                      wr_en,
    output logic [ADDR_W-1:0]         wr_addr,
    output logic [slfr_pkg::BYTE_W-1:0] wr_data,
    output logic                      cmd_push,
    output logic [CNT_W-1:0]          cmd_len
);
    import slfr_pkg::*;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic [BYTE_W-1:0] len_reg, len_next;

    logic [CNT_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0] check_upd;
    logic [TGT_W-1:0]  target;

    assign cnt_inc   = count_reg + 1'b1;
    assign check_upd = check_reg ^ rx_byte;
    assign target    = TGT_W'(len_reg) + TGT_W'(FRAME_OVERHEAD);

    always_comb
    begin
        count_next = count_reg;
        check_next = check_reg;
        len_next   = len_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data    = rx_byte;
        cmd_push   = 1'b0;
        cmd_len    = cnt_inc;
        if (accept)
        begin
            if (kind == KIND_REARM)
            begin
                count_next = '0;
                check_next = '0;
            end
            else if (count_reg == '0)
            begin
                count_next = '0;
                check_next = '0;
                if (rx_byte == SYNC_FIRST)
                begin
                    wr_en      = 1'b1;
                    count_next = CNT_W'(1);
                end
            end
            else if (count_reg == CNT_W'(1))
            begin
                count_next = '0;
                check_next = '0;
                if (rx_byte == SYNC_SECOND)
                begin
                    wr_en      = 1'b1;
                    count_next = CNT_W'(FIRST_PAYLOAD);
                end
            end
            else if (count_reg != CNT_W'(BUFFER_DEPTH))
            begin
                wr_en      = 1'b1;
                check_next = check_upd;
                count_next = cnt_inc;
                if (count_reg == CNT_W'(LENGTH_INDEX))
                begin
                    len_next = rx_byte;
                end
                // length byte is already in len_reg by the time the count can match
                if (cnt_inc >= CNT_W'(FRAME_OVERHEAD) && TGT_W'(cnt_inc) == target)
                begin
                    if (check_upd == '0)
                    begin
                        cmd_push = 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                        check_next = '0;
                    end
                end
            end
            else
            begin
                // buffer full: drop the item and start over
                count_next = '0;
                check_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            check_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            check_reg <= check_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

[rtl/slfr_cmdq.sv]
// Two-entry command queue carrying frame lengths from the front end to the readout.
module slfr_cmdq #(
    parameter int CNT_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [CNT_W-1:0] push_len,
    input  logic             pop,
    output logic             empty,
    output logic [CNT_W-1:0] head_len
);
    import slfr_pkg::*;

    localparam int QDEPTH = 2;

    logic [CNT_W-1:0] entry_reg [QDEPTH];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign empty    = (count_reg == 2'd0);
    assign head_len = entry_reg[rd_ptr_reg];
    assign do_push  = push && (count_reg != 2'(QDEPTH));
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_len;
        end
    end

endmodule

[rtl/slfr_back.sv]
// Readout: holds the frame store and streams a validated frame out from byte 2 on.
module slfr_back #(
    parameter int BUFFER_DEPTH = slfr_pkg::BUFFER_DEPTH_DEF,
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1),
    localparam int ADDR_W = $clog2(BUFFER_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [slfr_pkg::BYTE_W-1:0] wr_data,
    input  logic                        cmd_valid,
    input  logic [CNT_W-1:0]            cmd_len,
    output logic                        cmd_take,
    output logic                        busy,
    input  logic                        pop,
    output logic                        empty,
    output logic [slfr_pkg::BYTE_W-1:0] frame_byte,
    output logic [slfr_pkg::POS_W-1:0]  byte_position,
    output logic [slfr_pkg::FLEN_W-1:0] frame_length,
    output logic                        last
);
    import slfr_pkg::*;

    logic [BYTE_W-1:0] mem [BUFFER_DEPTH];

    back_state_t      state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic              out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0] frame_byte_reg;
    logic [POS_W-1:0]  byte_position_reg;
    logic [FLEN_W-1:0] frame_length_reg;
    logic              last_reg;

    logic [CNT_W-1:0]  pos_inc;
    logic              is_last;
    logic              issue;
    logic              pop_fire;

    assign pos_inc  = CNT_W'(pos_reg) + 1'b1;
    assign is_last  = (pos_inc == len_reg);
    assign pop_fire = pop && out_valid_reg;
    assign issue    = (state_reg == BK_RUN) && (!out_valid_reg || pop);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (issue && is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_take = 1'b0;
        busy     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                cmd_take = cmd_valid;
            end
            BK_RUN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                cmd_take = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        if (cmd_take)
        begin
            pos_next = ADDR_W'(FIRST_PAYLOAD);
            len_next = cmd_len;
        end
        else if (issue)
        begin
            pos_next = pos_inc[ADDR_W-1:0];
        end
        // a read issued on a pop refills the output register in the same edge
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop_fire)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        len_reg <= len_next;
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            frame_byte_reg    <= mem[pos_reg];
            byte_position_reg <= POS_W'(pos_reg);
            frame_length_reg  <= FLEN_W'(len_reg);
            last_reg          <= is_last;
        end
    end

    assign empty         = !out_valid_reg;
    assign frame_byte    = frame_byte_reg;
    assign byte_position = byte_position_reg;
    assign frame_length  = frame_length_reg;
    assign last          = last_reg;

endmodule

[rtl/sync_length_xor_frame_receiver.sv]
// Sync/length/XOR frame receiver top level: front end, command queue and readout.
// One byte item is taken per clock while no frame is waiting to be read out. When the byte
// that completes a frame with a zero XOR check arrives, full rises on the next cycle and stays
// high until the readout has read every byte of the frame (positions 2 onward) from the frame
// store; the store has a single read port and gives one result per cycle while pop is held, so
// a frame holds the input while the command is handed over, then while each result is read,
// and for as long as the consumer stalls.
// Results come out of a one-deep output register. A rearm item clears the count at once.
module sync_length_xor_frame_receiver #(
    parameter int BUFFER_DEPTH = slfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        kind,
    input  logic [slfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [slfr_pkg::BYTE_W-1:0] frame_byte,
    output logic [slfr_pkg::POS_W-1:0]  byte_position,
    output logic [slfr_pkg::FLEN_W-1:0] frame_length,
    output logic                        last
);
    import slfr_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = $clog2(BUFFER_DEPTH);

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              cmd_push;
    logic [CNT_W-1:0]  cmd_len;
    logic              q_empty;
    logic [CNT_W-1:0]  q_len;
    logic              cmd_take;
    logic              back_busy;

    // hold the input while a frame is pending so the store is not overwritten
    assign full   = !q_empty || back_busy;
    assign accept = push && !full;

    slfr_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .rx_byte (rx_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .cmd_push(cmd_push),
        .cmd_len (cmd_len)
    );

    slfr_cmdq #(
        .CNT_W(CNT_W)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .push_len(cmd_len),
        .pop     (cmd_take),
        .empty   (q_empty),
        .head_len(q_len)
    );

    slfr_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .cmd_valid    (!q_empty),
        .cmd_len      (q_len),
        .cmd_take     (cmd_take),
        .busy         (back_busy),
        .pop          (pop),
        .empty        (empty),
        .frame_byte   (frame_byte),
        .byte_position(byte_position),
        .frame_length (frame_length),
        .last         (last)
    );

`ifndef SYNTHESIS
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> q_empty)
        else $error("frame command posted while another is pending");

    a_no_write_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !back_busy)
        else $error("frame store written during readout");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |=> !empty)
        else $error("result stream broke before the last byte");
`endif

endmodule
